// ===== sv/ztt_pkg.sv =====
// Shared types and command codes for the Zobrist transposition table.
`default_nettype none

package ztt_pkg;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_TOGGLE = 3'd2;
    localparam logic [2:0] CMD_STORE  = 3'd3;
    localparam logic [2:0] CMD_PROBE  = 3'd4;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_TOGGLE,
        OP_STORE,
        OP_PROBE
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        op_t         op;
        logic        sq_ok;
        logic [31:0] key_low;
        logic [63:0] key_high;
        logic        table_select;
        logic [1:0]  entry_kind;
        logic [15:0] score_in;
        logic [7:0]  search_depth;
        logic [15:0] alpha;
        logic [15:0] beta;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] score;
        logic [7:0]  depth;
    } meta_t;

    typedef struct packed {
        logic [63:0] checksum;
        meta_t       meta;
    } entry_t;

    typedef struct packed {
        logic [31:0] short_key;
        logic [63:0] long_key;
    } key_pair_t;

endpackage

`default_nettype wire

// ===== sv/ztt_if.sv =====
// Request and response channel interfaces of the transposition table.
`default_nettype none

interface ztt_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic               stone_type;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [31:0]        key_low;
    logic [63:0]        key_high;
    logic               table_select;
    logic [1:0]         entry_kind;
    logic signed [15:0] score_in;
    logic [7:0]         search_depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;

    modport source (
        output valid, cmd, stone_type, row, col, key_low, key_high, table_select,
               entry_kind, score_in, search_depth, alpha, beta,
        input  ready
    );
    modport sink (
        input  valid, cmd, stone_type, row, col, key_low, key_high, table_select,
               entry_kind, score_in, search_depth, alpha, beta,
        output ready
    );
endinterface

interface ztt_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [15:0] score_out;

    modport source (
        output valid, hit, score_out,
        input  ready
    );
    modport sink (
        input  valid, hit, score_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ztt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ztt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/ztt_front.sv =====
// Front end: accept request beats, decode and range-check them, queue them.
`default_nettype none

module ztt_front #(
    parameter int BOARD_SIZE  = 15,
    parameter int STONE_KINDS = 2,
    parameter int KEY_AW      = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ztt_req_if.sink              req,
    input  logic                 clearing,
    input  logic                 pop,
    output logic                 head_valid,
    output ztt_pkg::item_t       head_item,
    output logic [KEY_AW-1:0]    head_sq
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ztt_pkg::item_t    item_reg [QUEUE_DEPTH];
    logic [KEY_AW-1:0] sq_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     rptr_reg, rptr_next;
    logic [CW-1:0]     count_reg, count_next;

    ztt_pkg::item_t    dec_item;
    logic [KEY_AW-1:0] dec_sq;
    ztt_pkg::op_t      dec_op;
    logic              push;

    always_comb
    begin
        unique case (req.cmd)
            ztt_pkg::CMD_LOAD:   dec_op = ztt_pkg::OP_LOAD;
            ztt_pkg::CMD_CLEAR:  dec_op = ztt_pkg::OP_CLEAR;
            ztt_pkg::CMD_TOGGLE: dec_op = ztt_pkg::OP_TOGGLE;
            ztt_pkg::CMD_STORE:  dec_op = ztt_pkg::OP_STORE;
            ztt_pkg::CMD_PROBE:  dec_op = ztt_pkg::OP_PROBE;
            default:             dec_op = ztt_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        dec_item.op           = dec_op;
        dec_item.sq_ok        = (32'(req.stone_type) < STONE_KINDS)
                             && (32'(req.row) < BOARD_SIZE)
                             && (32'(req.col) < BOARD_SIZE);
        dec_item.key_low      = req.key_low;
        dec_item.key_high     = req.key_high;
        dec_item.table_select = req.table_select;
        dec_item.entry_kind   = req.entry_kind;
        dec_item.score_in     = req.score_in;
        dec_item.search_depth = req.search_depth;
        dec_item.alpha        = req.alpha;
        dec_item.beta         = req.beta;
        dec_sq = KEY_AW'((32'(req.stone_type) * BOARD_SIZE + 32'(req.row)) * BOARD_SIZE
                         + 32'(req.col));
    end

    assign req.ready = !clearing && (count_reg != CW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wptr_reg] <= dec_item;
            sq_reg[wptr_reg]   <= dec_sq;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_item  = item_reg[rptr_reg];
    assign head_sq    = sq_reg[rptr_reg];

endmodule

`default_nettype wire

// ===== sv/ztt_back.sv =====
// Back end: position keys, key and entry memories, clearing sweep, response register.
`default_nettype none

module ztt_back #(
    parameter int INDEX_BITS  = 16,
    parameter int KEY_ENTRIES = 450,
    parameter int KEY_AW      = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ztt_pkg::item_t    head_item,
    input  logic [KEY_AW-1:0] head_sq,
    output logic              pop,
    output logic              clearing,
    ztt_rsp_if.source         rsp
);

    localparam int SLOT_W = INDEX_BITS + 1;
    localparam int SLOTS  = 1 << SLOT_W;
    localparam int KEY_W  = $bits(ztt_pkg::key_pair_t);
    localparam int ENT_W  = $bits(ztt_pkg::entry_t);

    ztt_pkg::back_state_t state_reg, state_next;
    logic [SLOT_W-1:0]    clr_reg, clr_next;
    logic [31:0]          short_key_reg, short_key_next;
    logic [63:0]          long_key_reg, long_key_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 hit_reg, hit_next;
    logic [15:0]          score_reg, score_next;

    logic                 key_we, key_re;
    ztt_pkg::key_pair_t   key_wdata, key_rdata;
    logic                 ent_we, ent_re;
    logic [SLOT_W-1:0]    ent_waddr, slot;
    ztt_pkg::entry_t      ent_wdata, ent_rdata;
    ztt_pkg::entry_t      store_entry;
    logic                 kind_ok, probe_hit;

    ztt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (head_sq),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (head_sq),
        .rdata (key_rdata)
    );

    ztt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (slot),
        .rdata (ent_rdata)
    );

    assign slot = {head_item.table_select, short_key_reg[INDEX_BITS-1:0]};

    always_comb
    begin
        key_wdata.short_key    = head_item.key_low;
        key_wdata.long_key     = head_item.key_high;
        store_entry.checksum   = long_key_reg;
        store_entry.meta.valid = 1'b1;
        store_entry.meta.kind  = head_item.entry_kind;
        store_entry.meta.score = head_item.score_in;
        store_entry.meta.depth = head_item.search_depth;
    end

    always_comb
    begin
        unique case (ent_rdata.meta.kind)
            ztt_pkg::KIND_EXACT: kind_ok = 1'b1;
            ztt_pkg::KIND_LOWER: kind_ok = $signed(ent_rdata.meta.score)
                                           >= $signed(head_item.beta);
            ztt_pkg::KIND_UPPER: kind_ok = $signed(ent_rdata.meta.score)
                                           <= $signed(head_item.alpha);
            default:             kind_ok = 1'b0;
        endcase
        probe_hit = ent_rdata.meta.valid
                 && (ent_rdata.meta.depth >= head_item.search_depth)
                 && (ent_rdata.checksum == long_key_reg)
                 && kind_ok;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        short_key_next = short_key_reg;
        long_key_next  = long_key_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        hit_next       = hit_reg;
        score_next     = score_reg;
        key_we         = 1'b0;
        key_re         = 1'b0;
        ent_we         = 1'b0;
        ent_re         = 1'b0;
        ent_waddr      = slot;
        ent_wdata      = store_entry;
        pop            = 1'b0;
        clearing       = 1'b0;

        unique case (state_reg)
            ztt_pkg::BK_CLEAR:
            begin
                clearing  = 1'b1;
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                ent_wdata = '0;
                clr_next  = clr_reg + SLOT_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ztt_pkg::BK_IDLE;
                end
            end
            ztt_pkg::BK_IDLE:
            begin
                if (head_valid && (!rsp_valid_reg || rsp.ready))
                begin
                    key_re     = 1'b1;
                    ent_re     = 1'b1;
                    state_next = ztt_pkg::BK_EXEC;
                end
            end
            ztt_pkg::BK_EXEC:
            begin
                pop            = 1'b1;
                rsp_valid_next = 1'b1;
                hit_next       = 1'b0;
                score_next     = '0;
                state_next     = ztt_pkg::BK_IDLE;
                unique case (head_item.op)
                    ztt_pkg::OP_LOAD:
                    begin
                        key_we = head_item.sq_ok;
                    end
                    ztt_pkg::OP_CLEAR:
                    begin
                        short_key_next = '0;
                        long_key_next  = '0;
                    end
                    ztt_pkg::OP_TOGGLE:
                    begin
                        if (head_item.sq_ok)
                        begin
                            short_key_next = short_key_reg ^ key_rdata.short_key;
                            long_key_next  = long_key_reg ^ key_rdata.long_key;
                        end
                    end
                    ztt_pkg::OP_STORE:
                    begin
                        ent_we = 1'b1;
                    end
                    ztt_pkg::OP_PROBE:
                    begin
                        if (probe_hit)
                        begin
                            hit_next   = 1'b1;
                            score_next = ent_rdata.meta.score;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ztt_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ztt_pkg::BK_CLEAR;
            clr_reg       <= '0;
            short_key_reg <= '0;
            long_key_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            short_key_reg <= short_key_next;
            long_key_reg  <= long_key_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        score_reg <= score_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.score_out = score_reg;

endmodule

`default_nettype wire

// ===== sv/zobrist_transposition_table.sv =====
// Zobrist-hashed transposition table: top level joining front end and back end.
// Items go via the front queue, memory read, update and the response register.
// The back end ends each item's read-then-update sequence on the key and entry
// memories before it takes the next; the front queue holds 2 items.
// Reset: position keys clear at once; a sweep of 2**(INDEX_BITS+1) slots then
// clears the entry valid bits, and no request beat is accepted until it ends.
`default_nettype none

module zobrist_transposition_table #(
    parameter int INDEX_BITS  = 16,
    parameter int BOARD_SIZE  = 15,
    parameter int STONE_KINDS = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    ztt_req_if.sink   req,
    ztt_rsp_if.source rsp
);

    localparam int KEY_ENTRIES = STONE_KINDS * BOARD_SIZE * BOARD_SIZE;
    localparam int KEY_AW      = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;

    logic              head_valid;
    ztt_pkg::item_t    head_item;
    logic [KEY_AW-1:0] head_sq;
    logic              pop;
    logic              clearing;

    ztt_front #(
        .BOARD_SIZE  (BOARD_SIZE),
        .STONE_KINDS (STONE_KINDS),
        .KEY_AW      (KEY_AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .clearing   (clearing),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_sq    (head_sq)
    );

    ztt_back #(
        .INDEX_BITS  (INDEX_BITS),
        .KEY_ENTRIES (KEY_ENTRIES),
        .KEY_AW      (KEY_AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_sq    (head_sq),
        .pop        (pop),
        .clearing   (clearing),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== sv/ztt_checker.sv =====
// Port-level assertions for the transposition table, bound to the top level.
`default_nettype none

module ztt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic [15:0] rsp_score
);

    localparam logic [2:0] MAX_OUTSTANDING = 3'd3;

    logic [2:0] outstanding_reg, outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg + 3'(req_valid && req_ready)
                         - 3'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_score))
        else $error("response payload changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 3'd0)
        else $error("response beat without an accepted request");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= MAX_OUTSTANDING)
        else $error("more requests in flight than the design can hold");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_score == 16'd0)
        else $error("miss response carries a nonzero score");

endmodule

bind zobrist_transposition_table ztt_checker u_ztt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_hit   (rsp.hit),
    .rsp_score (rsp.score_out)
);

`default_nettype wire

// ===== tb/sv/zobrist_transposition_table_tb.sv =====
// Testbench for the Zobrist transposition table: directed table, random search sequences.
`default_nettype none

module zobrist_transposition_table_tb;
    import ztt_pkg::*;

    localparam int INDEX_BITS  = 16;
    localparam int BOARD       = 15;
    localparam int KINDS       = 2;
    localparam int KEY_ENTRIES = KINDS * BOARD * BOARD;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 1000000;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [2:0] CMD_LAST      = 3'd7;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               stone_type;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [31:0]        key_low;
        logic [63:0]        key_high;
        logic               table_select;
        logic [1:0]         entry_kind;
        logic signed [15:0] score_in;
        logic [7:0]         search_depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } command_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] score;
    } reply_t;

    typedef struct packed {
        logic   fixed;
        reply_t r;
    } typed_reply_t;

    typedef struct packed {
        command_t c;
        reply_t   r;
    } step_t;

    logic clk;
    logic rst_n;

    ztt_req_if req_ch ();
    ztt_rsp_if rsp_ch ();

    zobrist_transposition_table #(
        .INDEX_BITS (INDEX_BITS),
        .BOARD_SIZE (BOARD),
        .STONE_KINDS(KINDS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // predictor state
    logic [31:0] sq_key_short [0:KEY_ENTRIES-1];
    logic [63:0] sq_key_long  [0:KEY_ENTRIES-1];
    logic [31:0] pos_short;
    logic [63:0] pos_long;
    logic [63:0] slot_sum  [int];
    meta_t       slot_meta [int];

    typed_reply_t typed_replies [$];
    reply_t       replies_due [$];
    step_t        opening_steps [$];

    bit gen_loaded [0:KEY_ENTRIES-1];
    int loaded_squares [$];

    int errors;
    int cycle_count;
    int accepted_items;
    int items_sent;
    int burst_left;
    int n_loads, n_clears, n_toggles, n_stores, n_probes, n_hits, n_unused;

    function automatic int square_of(command_t c);
        if (c.stone_type >= KINDS || c.row >= BOARD || c.col >= BOARD)
            return -1;
        return (int'(c.stone_type) * BOARD + int'(c.row)) * BOARD + int'(c.col);
    endfunction

    function automatic reply_t zobrist_apply(command_t c);
        reply_t r;
        int     sq;
        int     slot;
        meta_t  m;
        logic   ok;
        r = '0;
        ok = 1'b0;
        sq = square_of(c);
        slot = int'({c.table_select, pos_short[INDEX_BITS-1:0]});
        case (c.cmd)
            CMD_LOAD:
                if (sq >= 0)
                begin
                    sq_key_short[sq] = c.key_low;
                    sq_key_long[sq]  = c.key_high;
                end
            CMD_CLEAR:
            begin
                pos_short = '0;
                pos_long  = '0;
            end
            CMD_TOGGLE:
                if (sq >= 0)
                begin
                    pos_short ^= sq_key_short[sq];
                    pos_long  ^= sq_key_long[sq];
                end
            CMD_STORE:
            begin
                m.valid = 1'b1;
                m.kind  = c.entry_kind;
                m.score = c.score_in;
                m.depth = c.search_depth;
                slot_sum[slot]  = pos_long;
                slot_meta[slot] = m;
            end
            CMD_PROBE:
                if (slot_meta.exists(slot))
                begin
                    m = slot_meta[slot];
                    if (m.valid && m.depth >= c.search_depth && slot_sum[slot] == pos_long)
                    begin
                        case (m.kind)
                            KIND_EXACT: ok = 1'b1;
                            KIND_LOWER: ok = $signed(m.score) >= c.beta;
                            KIND_UPPER: ok = $signed(m.score) <= c.alpha;
                            default:    ok = 1'b0;
                        endcase
                        if (ok)
                        begin
                            r.hit   = 1'b1;
                            r.score = m.score;
                        end
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic command_t mk(logic [2:0] op, logic st, logic [3:0] r, logic [3:0] cl,
                                    logic [31:0] kl, logic [63:0] kh, logic ts,
                                    logic [1:0] kind, int sc, int dp, int al, int bt);
        command_t c;
        c.cmd          = op;
        c.stone_type   = st;
        c.row          = r;
        c.col          = cl;
        c.key_low      = kl;
        c.key_high     = kh;
        c.table_select = ts;
        c.entry_kind   = kind;
        c.score_in     = 16'(sc);
        c.search_depth = 8'(dp);
        c.alpha        = 16'(al);
        c.beta         = 16'(bt);
        return c;
    endfunction

    function automatic step_t step_of(command_t c, logic h, int s);
        step_t t;
        t.c       = c;
        t.r.hit   = h;
        t.r.score = 16'(s);
        return t;
    endfunction

    function automatic command_t rand_command();
        command_t c;
        c.cmd          = 3'($urandom);
        c.stone_type   = 1'($urandom);
        c.row          = 4'($urandom);
        c.col          = 4'($urandom);
        c.key_low      = $urandom;
        c.key_high     = {$urandom, $urandom};
        c.table_select = 1'($urandom);
        c.entry_kind   = 2'($urandom);
        c.score_in     = 16'($urandom);
        c.search_depth = 8'($urandom);
        c.alpha        = 16'($urandom);
        c.beta         = 16'($urandom);
        return c;
    endfunction

    function automatic command_t on_square(command_t c, int sq);
        command_t o;
        o = c;
        o.stone_type = 1'(sq / (BOARD * BOARD));
        o.row        = 4'((sq / BOARD) % BOARD);
        o.col        = 4'(sq % BOARD);
        return o;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic send(command_t c, logic fixed, reply_t r);
        typed_reply_t t;
        int           sq;
        t.fixed = fixed;
        t.r     = r;
        sq = square_of(c);
        if (c.cmd == CMD_LOAD && sq >= 0 && !gen_loaded[sq])
        begin
            gen_loaded[sq] = 1'b1;
            loaded_squares.push_back(sq);
        end
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        typed_replies.push_back(t);
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c.cmd;
        req_ch.stone_type   <= c.stone_type;
        req_ch.row          <= c.row;
        req_ch.col          <= c.col;
        req_ch.key_low      <= c.key_low;
        req_ch.key_high     <= c.key_high;
        req_ch.table_select <= c.table_select;
        req_ch.entry_kind   <= c.entry_kind;
        req_ch.score_in     <= c.score_in;
        req_ch.search_depth <= c.search_depth;
        req_ch.alpha        <= c.alpha;
        req_ch.beta         <= c.beta;
        do
            @(posedge clk);
        while (!req_ch.ready);
        burst_left--;
        if (c.cmd <= CMD_PROBE)
            items_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d replies outstanding",
                     $time, cycle_count, replies_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        command_t     c;
        reply_t       p;
        typed_reply_t t;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            c.cmd          = req_ch.cmd;
            c.stone_type   = req_ch.stone_type;
            c.row          = req_ch.row;
            c.col          = req_ch.col;
            c.key_low      = req_ch.key_low;
            c.key_high     = req_ch.key_high;
            c.table_select = req_ch.table_select;
            c.entry_kind   = req_ch.entry_kind;
            c.score_in     = req_ch.score_in;
            c.search_depth = req_ch.search_depth;
            c.alpha        = req_ch.alpha;
            c.beta         = req_ch.beta;
            p = zobrist_apply(c);
            t = typed_replies.pop_front();
            replies_due.push_back(t.fixed ? t.r : p);
            accepted_items++;
            case (c.cmd)
                CMD_LOAD:   n_loads++;
                CMD_CLEAR:  n_clears++;
                CMD_TOGGLE: n_toggles++;
                CMD_STORE:  n_stores++;
                CMD_PROBE:
                begin
                    n_probes++;
                    n_hits += int'(p.hit);
                end
                default:    n_unused++;
            endcase
        end
    end

    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply beat, expected none, actual hit %0b score %0d",
                         $time, rsp_ch.hit, rsp_ch.score_out);
            end
            else
            begin
                e = replies_due.pop_front();
                if (rsp_ch.hit !== e.hit)
                begin
                    errors++;
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, e.hit, rsp_ch.hit);
                end
                if (rsp_ch.score_out !== e.score)
                begin
                    errors++;
                    $display("%0t: score_out mismatch, expected %0d actual %0d",
                             $time, e.score, rsp_ch.score_out);
                end
            end
        end
    end

    // receiver: own stall pattern, one long hold once the flow is going
    initial
    begin
        int run;
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && accepted_items >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
            repeat (run) @(posedge clk);
            run = $urandom_range(0, 5);
            if (run > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (run) @(posedge clk);
            end
        end
    end

    initial
    begin
        command_t c;
        int       base;
        int       sq;
        int       sc;
        int       dp;
        int       d;
        int       choice;
        logic     ts;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_LOAD;
        req_ch.stone_type   <= 1'b0;
        req_ch.row          <= '0;
        req_ch.col          <= '0;
        req_ch.key_low      <= '0;
        req_ch.key_high     <= '0;
        req_ch.table_select <= 1'b0;
        req_ch.entry_kind   <= KIND_EXACT;
        req_ch.score_in     <= '0;
        req_ch.search_depth <= '0;
        req_ch.alpha        <= '0;
        req_ch.beta         <= '0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_LOAD, 0, 0, 0, '1, '1, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_LOAD, 1, 14, 14, 32'h1, 64'h8000_0000_0000_0001, 0, KIND_EXACT,
               0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_LOAD, 1, 15, 0, 32'h1234_5678, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_TOGGLE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_STORE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 32767, 255, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 255, 0, 0), 1, 32767));
        opening_steps.push_back(step_of(
            mk(CMD_STORE, 0, 0, 0, '0, '0, 1, KIND_LOWER, -32768, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 1, KIND_EXACT, 0, 0, 0, -32768), 1, -32768));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 1, KIND_EXACT, 0, 0, 0, -32767), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_TOGGLE, 1, 14, 14, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_STORE, 0, 0, 0, '0, '0, 0, KIND_UPPER, 0, 10, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 10, 0, 0), 1, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 10, -1, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 11, 32767, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_STORE, 0, 0, 0, '0, '0, 1, KIND_RESERVED, 5, 1, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 1, KIND_EXACT, 0, 0, 32767, -32768), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_TOGGLE, 0, 15, 15, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_TOGGLE, 1, 14, 14, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 255, 0, 0), 1, 32767));
        opening_steps.push_back(step_of(
            mk(CMD_LOAD, 0, 7, 7, 32'h0001_0000, 64'h1, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_TOGGLE, 0, 7, 7, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 0, 32767, -32768), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_LAST, 1, 15, 15, '1, '1, 1, KIND_RESERVED, -1, 255, -1, -1), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_CLEAR, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));
        opening_steps.push_back(step_of(
            mk(CMD_PROBE, 0, 0, 0, '0, '0, 0, KIND_EXACT, 0, 0, 0, 0), 0, 0));

        foreach (opening_steps[i])
            send(opening_steps[i].c, 1'b1, opening_steps[i].r);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 99);
            if (loaded_squares.size() < 4 || choice < 10)
            begin
                sq = $urandom_range(0, KEY_ENTRIES - 1);
                c = on_square(rand_command(), sq);
                c.cmd = CMD_LOAD;
                if ($urandom_range(0, 3) == 0)
                    c.key_low[15:0] = '0;
                send(c, 1'b0, '0);
            end
            else if (choice < 72)
            begin
                // make a move, store, probe around the stored bound, unmake
                sq = loaded_squares[$urandom_range(0, loaded_squares.size() - 1)];
                c = on_square(rand_command(), sq);
                c.cmd = CMD_TOGGLE;
                send(c, 1'b0, '0);
                ts = 1'($urandom);
                d = $urandom_range(0, 200);
                sc = $urandom_range(0, 1) ? int'($signed(16'($urandom))) : d - 100;
                dp = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
                c = rand_command();
                c.cmd = CMD_STORE;
                c.table_select = ts;
                c.entry_kind = ($urandom_range(0, 9) == 0) ? KIND_RESERVED
                                                           : 2'($urandom_range(0, 2));
                c.score_in = 16'(sc);
                c.search_depth = 8'(dp);
                send(c, 1'b0, '0);
                repeat ($urandom_range(1, 3))
                begin
                    c = rand_command();
                    c.cmd = CMD_PROBE;
                    if ($urandom_range(0, 9) != 0)
                        c.table_select = ts;
                    d = $urandom_range(0, 4);
                    c.search_depth = 8'(clamp(dp + d - 2, 0, 255));
                    d = $urandom_range(0, 6);
                    c.alpha = 16'(clamp(sc + d - 3, -32768, 32767));
                    d = $urandom_range(0, 6);
                    c.beta = 16'(clamp(sc + d - 3, -32768, 32767));
                    send(c, 1'b0, '0);
                end
                c = on_square(rand_command(), sq);
                c.cmd = CMD_TOGGLE;
                send(c, 1'b0, '0);
                if ($urandom_range(0, 1) == 0)
                begin
                    c = rand_command();
                    c.cmd = CMD_PROBE;
                    c.search_depth = 8'($urandom_range(0, 12));
                    send(c, 1'b0, '0);
                end
            end
            else if (choice < 76)
            begin
                c = rand_command();
                c.cmd = CMD_CLEAR;
                send(c, 1'b0, '0);
            end
            else
            begin
                c = rand_command();
                sq = square_of(c);
                if (c.cmd == CMD_TOGGLE && sq >= 0 && !gen_loaded[sq])
                    c = on_square(c, loaded_squares[$urandom_range(0, loaded_squares.size() - 1)]);
                send(c, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (replies_due.size() != 0 || typed_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            errors += replies_due.size();
            $display("%0t: %0d replies never arrived", $time, replies_due.size());
        end

        $display("Ran %0d commands: %0d loads, %0d toggles, %0d stores, %0d clears, %0d unused.",
                 accepted_items, n_loads, n_toggles, n_stores, n_clears, n_unused);
        $display("Probes %0d with %0d hits, long receiver hold included; %0d errors.",
                 n_probes, n_hits, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
